// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the port-level checker of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, switched off while reset is high.
`define ASSERT_CLK_RST(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Assertion sampled on the rising clock edge that also holds during reset.
`define ASSERT_CLK(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== hdl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSU package
// Types, character codes, parser modes and helper functions shared by the
// JSON string unescaper modules.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int MaxResults = 6;

   // Parser modes.
   localparam logic [2:0] ModeIdle   = 3'd0;
   localparam logic [2:0] ModeStr    = 3'd1;
   localparam logic [2:0] ModeEsc    = 3'd2;
   localparam logic [2:0] ModeHex    = 3'd3;
   localparam logic [2:0] ModeWaitBs = 3'd4;
   localparam logic [2:0] ModeWaitU  = 3'd5;
   localparam logic [2:0] ModeLowHex = 3'd6;

   // Result status codes.
   localparam logic [1:0] StatusData    = 2'd0;
   localparam logic [1:0] StatusClosed  = 2'd1;
   localparam logic [1:0] StatusEnded   = 2'd2;
   localparam logic [1:0] StatusNoQuote = 2'd3;

   // Character codes.
   localparam logic [7:0] CharNul       = 8'h00;
   localparam logic [7:0] CharQuote     = 8'h22;
   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharQuestion  = 8'h3F;
   localparam logic [7:0] CharU         = 8'h75;
   localparam logic [7:0] CharB         = 8'h62;
   localparam logic [7:0] CharF         = 8'h66;
   localparam logic [7:0] CharN         = 8'h6E;
   localparam logic [7:0] CharR         = 8'h72;
   localparam logic [7:0] CharT         = 8'h74;
   localparam logic [7:0] CtlBackspace  = 8'h08;
   localparam logic [7:0] CtlFormFeed   = 8'h0C;
   localparam logic [7:0] CtlLineFeed   = 8'h0A;
   localparam logic [7:0] CtlReturn     = 8'h0D;
   localparam logic [7:0] CtlTab        = 8'h09;

   // UTF-8 and surrogate constants.
   localparam logic [7:0]  Utf8Lead2   = 8'hC0;
   localparam logic [7:0]  Utf8Lead3   = 8'hE0;
   localparam logic [7:0]  Utf8Lead4   = 8'hF0;
   localparam logic [7:0]  Utf8Cont    = 8'h80;
   localparam logic [5:0]  SurrHighTag = 6'b110110;   // 0xD800 to 0xDBFF
   localparam logic [5:0]  SurrLowTag  = 6'b110111;   // 0xDC00 to 0xDFFF
   localparam logic [20:0] SuppBase    = 21'h10000;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  hex_count;
      logic [15:0] code_accum;
      logic [15:0] held_high;
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [1:0] status;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      rsp_item_type [MaxResults-1:0] items;
      logic [2:0]                    count;
   } result_set_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } enc_type;

   function automatic rsp_item_type data_item(input logic [7:0] b);
      rsp_item_type r;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      r.status     = StatusData;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic rsp_item_type status_item(input logic [1:0] st);
      rsp_item_type r;
      r.out_byte   = 8'h00;
      r.byte_valid = 1'b0;
      r.status     = st;
      r.last       = 1'b0;
      return r;
   endfunction

   // Returns {ok, value}; ok is low for a byte that is not a hex digit.
   function automatic logic [4:0] hex_lookup(input logic [7:0] b);
      logic [4:0] r;
      r = 5'b0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   function automatic enc_type utf8_pack(input logic [20:0] cp);
      enc_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.bytes[0] = cp[7:0];
         r.count    = 3'd1;
      end else if (cp < 21'h800) begin
         r.bytes[0] = Utf8Lead2 | {3'b0, cp[10:6]};
         r.bytes[1] = Utf8Cont | {2'b0, cp[5:0]};
         r.count    = 3'd2;
      end else if (cp < SuppBase) begin
         r.bytes[0] = Utf8Lead3 | {4'b0, cp[15:12]};
         r.bytes[1] = Utf8Cont | {2'b0, cp[11:6]};
         r.bytes[2] = Utf8Cont | {2'b0, cp[5:0]};
         r.count    = 3'd3;
      end else begin
         r.bytes[0] = Utf8Lead4 | {5'b0, cp[20:18]};
         r.bytes[1] = Utf8Cont | {2'b0, cp[17:12]};
         r.bytes[2] = Utf8Cont | {2'b0, cp[11:6]};
         r.bytes[3] = Utf8Cont | {2'b0, cp[5:0]};
         r.count    = 3'd4;
      end
      return r;
   endfunction

endpackage

// ===== hdl/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// JSU decoder
// Next parser state and the full list of results for one request byte.
// ----------------------------------------------------------------------------
module jsu_decode (
   input  jsu_pkg::state_type      state,
   input  logic [7:0]              in_byte,
   output jsu_pkg::state_type      state_next,
   output jsu_pkg::result_set_type results
);

   localparam logic [2:0] TailNone    = 3'd0;
   localparam logic [2:0] TailStr     = 3'd1;
   localparam logic [2:0] TailEsc     = 3'd2;
   localparam logic [2:0] TailEnc     = 3'd3;
   localparam logic [2:0] TailNoQuote = 3'd4;

   logic [4:0]             hex;
   logic                   hex_ok;
   logic [15:0]            acc_next;
   logic [2:0]             cnt_next;
   logic                   acc_high;
   logic                   acc_low;
   jsu_pkg::enc_type       enc_held;
   jsu_pkg::enc_type       enc_acc;
   jsu_pkg::enc_type       enc_join;
   jsu_pkg::rsp_item_type  str_item;
   logic                   str_n;
   logic [2:0]             str_mode;
   jsu_pkg::rsp_item_type  esc_item;
   logic                   esc_n;
   logic [2:0]             esc_mode;
   logic                   esc_is_u;
   logic                   a_on;
   logic                   a_join;
   logic                   q_on;
   logic [2:0]             t_kind;
   jsu_pkg::enc_type       a_enc;
   jsu_pkg::rsp_item_type  t_items [3];
   logic [1:0]             t_n;
   logic [3:0]             ca;
   logic [3:0]             qo;
   logic [3:0]             total;

   assign hex      = jsu_pkg::hex_lookup(in_byte);
   assign hex_ok   = hex[4];
   assign acc_next = {state.code_accum[11:0], hex[3:0]};
   assign cnt_next = state.hex_count + 3'd1;
   assign acc_high = (acc_next[15:10] == jsu_pkg::SurrHighTag);
   assign acc_low  = (acc_next[15:10] == jsu_pkg::SurrLowTag);
   assign enc_held = jsu_pkg::utf8_pack({5'b0, state.held_high});
   assign enc_acc  = jsu_pkg::utf8_pack({5'b0, acc_next});
   assign enc_join = jsu_pkg::utf8_pack(
                        jsu_pkg::SuppBase + {1'b0, state.held_high[9:0], acc_next[9:0]});

   // A byte taken as part of the string body.
   always_comb begin
      str_item = jsu_pkg::data_item(in_byte);
      str_n    = 1'b1;
      str_mode = jsu_pkg::ModeStr;
      if (in_byte == jsu_pkg::CharQuote) begin
         str_item = jsu_pkg::status_item(jsu_pkg::StatusClosed);
         str_mode = jsu_pkg::ModeIdle;
      end else if (in_byte == jsu_pkg::CharNul) begin
         str_item = jsu_pkg::status_item(jsu_pkg::StatusEnded);
         str_mode = jsu_pkg::ModeIdle;
      end else if (in_byte == jsu_pkg::CharBackslash) begin
         str_n    = 1'b0;
         str_mode = jsu_pkg::ModeEsc;
      end
   end

   // A byte that follows a backslash.
   always_comb begin
      esc_item = jsu_pkg::data_item(in_byte);
      esc_n    = 1'b1;
      esc_mode = jsu_pkg::ModeStr;
      esc_is_u = 1'b0;
      case (in_byte)
         jsu_pkg::CharNul: begin
            esc_item = jsu_pkg::status_item(jsu_pkg::StatusEnded);
            esc_mode = jsu_pkg::ModeIdle;
         end
         jsu_pkg::CharU: begin
            esc_n    = 1'b0;
            esc_mode = jsu_pkg::ModeHex;
            esc_is_u = 1'b1;
         end
         jsu_pkg::CharB: esc_item = jsu_pkg::data_item(jsu_pkg::CtlBackspace);
         jsu_pkg::CharF: esc_item = jsu_pkg::data_item(jsu_pkg::CtlFormFeed);
         jsu_pkg::CharN: esc_item = jsu_pkg::data_item(jsu_pkg::CtlLineFeed);
         jsu_pkg::CharR: esc_item = jsu_pkg::data_item(jsu_pkg::CtlReturn);
         jsu_pkg::CharT: esc_item = jsu_pkg::data_item(jsu_pkg::CtlTab);
         default: esc_item = jsu_pkg::data_item(in_byte);
      endcase
   end

   // Every result list is: an optional code point, an optional '?', then a tail.
   always_comb begin
      state_next = state;
      a_on       = 1'b0;
      a_join     = 1'b0;
      q_on       = 1'b0;
      t_kind     = TailNone;
      unique case (state.mode)
         jsu_pkg::ModeStr: t_kind = TailStr;
         jsu_pkg::ModeEsc: t_kind = TailEsc;
         jsu_pkg::ModeHex: begin
            if (!hex_ok) begin
               q_on   = 1'b1;
               t_kind = TailStr;
            end else begin
               state_next.code_accum = acc_next;
               state_next.hex_count  = cnt_next;
               if (cnt_next[2]) begin
                  if (acc_high) begin
                     state_next.held_high = acc_next;
                     state_next.mode      = jsu_pkg::ModeWaitBs;
                  end else begin
                     t_kind = TailEnc;
                  end
               end
            end
         end
         jsu_pkg::ModeWaitBs: begin
            if (in_byte == jsu_pkg::CharBackslash) begin
               state_next.mode = jsu_pkg::ModeWaitU;
            end else begin
               a_on   = 1'b1;
               t_kind = TailStr;
            end
         end
         jsu_pkg::ModeWaitU: begin
            if (in_byte == jsu_pkg::CharU) begin
               state_next.mode       = jsu_pkg::ModeLowHex;
               state_next.hex_count  = 3'd0;
               state_next.code_accum = 16'h0000;
            end else begin
               a_on   = 1'b1;
               t_kind = TailEsc;
            end
         end
         jsu_pkg::ModeLowHex: begin
            if (!hex_ok) begin
               a_on   = 1'b1;
               q_on   = 1'b1;
               t_kind = TailStr;
            end else begin
               state_next.code_accum = acc_next;
               state_next.hex_count  = cnt_next;
               if (cnt_next[2]) begin
                  a_on = 1'b1;
                  if (acc_low) begin
                     a_join          = 1'b1;
                     state_next.mode = jsu_pkg::ModeStr;
                  end else if (acc_high) begin
                     state_next.held_high = acc_next;
                     state_next.mode      = jsu_pkg::ModeWaitBs;
                  end else begin
                     t_kind = TailEnc;
                  end
               end
            end
         end
         default: begin
            if (in_byte == jsu_pkg::CharQuote) begin
               state_next.mode = jsu_pkg::ModeStr;
            end else begin
               t_kind = TailNoQuote;
            end
         end
      endcase

      t_items[0] = jsu_pkg::data_item(enc_acc.bytes[0]);
      t_items[1] = jsu_pkg::data_item(enc_acc.bytes[1]);
      t_items[2] = jsu_pkg::data_item(enc_acc.bytes[2]);
      t_n        = 2'd0;
      case (t_kind)
         TailStr: begin
            t_items[0]      = str_item;
            t_n             = {1'b0, str_n};
            state_next.mode = str_mode;
         end
         TailEsc: begin
            t_items[0]      = esc_item;
            t_n             = {1'b0, esc_n};
            state_next.mode = esc_mode;
            if (esc_is_u) begin
               state_next.hex_count  = 3'd0;
               state_next.code_accum = 16'h0000;
            end
         end
         TailEnc: begin
            t_n             = enc_acc.count[1:0];
            state_next.mode = jsu_pkg::ModeStr;
         end
         TailNoQuote: begin
            t_items[0]      = jsu_pkg::status_item(jsu_pkg::StatusNoQuote);
            t_n             = 2'd1;
            state_next.mode = jsu_pkg::ModeIdle;
         end
         default: t_n = 2'd0;
      endcase
   end

   assign a_enc = a_join ? enc_join : enc_held;
   assign ca    = a_on ? {1'b0, a_enc.count} : 4'd0;
   assign qo    = ca + {3'b0, q_on};
   assign total = qo + {2'b0, t_n};

   // Lay the three parts out in result order and mark the final one.
   always_comb begin
      for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
         if (4'(i) < ca) begin
            results.items[i] = jsu_pkg::data_item(a_enc.bytes[2'(i)]);
         end else if (4'(i) < qo) begin
            results.items[i] = jsu_pkg::data_item(jsu_pkg::CharQuestion);
         end else begin
            results.items[i] = t_items[2'(4'(i) - qo)];
         end
         results.items[i].last = (4'(i) == total - 4'd1);
      end
      results.count = total[2:0];
   end

endmodule

// ===== hdl/jsu_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// JSU response queue
// Holds the results of one request and hands them out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module jsu_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  jsu_pkg::result_set_type results,
   input  logic                    take_ready,
   output logic                    can_load,
   output logic                    head_valid,
   output jsu_pkg::rsp_item_type   head
);

   logic [2:0]            count_ff;
   logic [2:0]            count_in;
   jsu_pkg::rsp_item_type slots_ff [jsu_pkg::MaxResults];
   jsu_pkg::rsp_item_type slots_in [jsu_pkg::MaxResults];
   logic                  take;

   assign head_valid = (count_ff != 3'd0);
   assign head       = slots_ff[0];
   assign take       = head_valid && take_ready;
   assign can_load   = (count_ff == 3'd0) || ((count_ff == 3'd1) && take_ready);

   always_comb begin
      count_in = count_ff;
      slots_in = slots_ff;
      if (load) begin
         count_in = results.count;
         for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
            slots_in[i] = results.items[i];
         end
      end else if (take) begin
         count_in = count_ff - 3'd1;
         for (int i = 0; i < jsu_pkg::MaxResults - 1; i++) begin
            slots_in[i] = slots_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

endmodule

// ===== hdl/json_string_unescape_utf8.sv =====
// Latency: the first result of a request is offered in the cycle after the request is accepted.
// Throughput: one request per cycle while each request gives at most one result and the
// receiver is ready; a request that gives n results holds the result queue until they are
// taken, and the next request is taken in the cycle its last result is taken.
// Reset is synchronous and active high: the parser returns to idle, awaiting an opening
// quote, and any results not yet delivered are dropped.
// ----------------------------------------------------------------------------
// JSON string unescaper to UTF-8
// Parses a stream of raw bytes holding JSON string literals and delivers the
// decoded UTF-8 bytes, followed by one status result per string.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   // Request channel: one raw byte per request.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   // Response channel: one decoded byte or status per response.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [0] byte_valid, [2:1] status
   output logic       rsp_tlast    // last result caused by its request
);

   // The parser state: mode, hex digit count, gathered hex digits and a
   // high surrogate held while the parser looks for its low partner.
   jsu_pkg::state_type      state_ff;
   jsu_pkg::state_type      state_in;
   jsu_pkg::state_type      state_next;
   jsu_pkg::result_set_type results;
   jsu_pkg::rsp_item_type   head;
   logic                    accept;

   // The decoder works straight from the request byte and the parser state,
   // so the state and the queue both load at the accepting edge.
   jsu_decode u_decode (
      .state      (state_ff),
      .in_byte    (req_tdata),
      .state_next (state_next),
      .results    (results)
   );

   // The queue holds up to six results; a new request is taken whenever the
   // queue will be empty after this cycle, so single results stream without gaps.
   jsu_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .results    (results),
      .take_ready (rsp_tready),
      .can_load   (req_tready),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   assign accept = req_tvalid && req_tready;

   // The state only moves when a request is accepted.
   assign state_in = accept ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode       <= jsu_pkg::ModeIdle;
         state_ff.hex_count  <= 3'd0;
         state_ff.code_accum <= 16'h0000;
         state_ff.held_high  <= 16'h0000;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_tdata = head.out_byte;
   assign rsp_tuser = {head.status, head.byte_valid};
   assign rsp_tlast = head.last;

endmodule

// ===== hdl/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// JSU checker
// Port-level assertions for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);

   logic        is_data;
   logic        status_out;
   logic        rsp_stalled;
   logic [11:0] rsp_bits;

   assign is_data     = (rsp_tuser[2:1] == jsu_pkg::StatusData);
   assign status_out  = rsp_tvalid && !is_data;
   assign rsp_stalled = rsp_tvalid && !rsp_tready;
   assign rsp_bits    = {rsp_tdata, rsp_tuser, rsp_tlast};

   // Reset drops every pending response.
   `ASSERT_CLK(a_reset_empties, clock, reset |=> !rsp_tvalid)

   // A response carries a byte exactly when its status says data.
   `ASSERT_CLK_RST(a_valid_matches_status, clock, reset, rsp_tvalid |-> (rsp_tuser[0] == is_data))

   // A status response closes its request's run and carries no byte.
   `ASSERT_CLK_RST(a_status_is_last, clock, reset, status_out |-> rsp_tlast && (rsp_tdata == 8'h00))

   // With nothing waiting to go out the block always takes a request.
   `ASSERT_CLK_RST(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready)

   // A stalled response holds still.
   `ASSERT_CLK_RST(a_rsp_stable, clock, reset, rsp_stalled |=> rsp_tvalid && $stable(rsp_bits))

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/utf8_unescape_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 unescape checker
// Watches both stream channels of the JSON string unescaper, predicts the
// decoded bytes and status results of every accepted raw byte, and compares
// each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_unescape_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] out_byte
   input  logic [2:0] rsp_tuser,   // [0] byte_valid, [2:1] status
   input  logic       rsp_tlast,
   output int         failures,
   output int         outstanding
);

   jsu_pkg::rsp_item_type decoded_q[$];
   logic [2:0]            parser_mode;
   logic [2:0]            digits_taken;
   logic [15:0]           code_gathered;
   logic [15:0]           high_half;
   int                    fail_count = 0;

   task automatic put_data(input logic [7:0] b);
      jsu_pkg::rsp_item_type r;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      r.status     = jsu_pkg::StatusData;
      r.last       = 1'b0;
      decoded_q.push_back(r);
   endtask

   // A status closes the string and always returns the parser to idle.
   task automatic put_status(input logic [1:0] st);
      jsu_pkg::rsp_item_type r;
      r        = '0;
      r.status = st;
      decoded_q.push_back(r);
      parser_mode = jsu_pkg::ModeIdle;
   endtask

   task automatic put_utf8(input logic [20:0] cp);
      if (cp < 21'h80) begin
         put_data(cp[7:0]);
      end else if (cp < 21'h800) begin
         put_data(8'hC0 | {3'b0, cp[10:6]});
         put_data(8'h80 | {2'b0, cp[5:0]});
      end else if (cp < 21'h10000) begin
         put_data(8'hE0 | {4'b0, cp[15:12]});
         put_data(8'h80 | {2'b0, cp[11:6]});
         put_data(8'h80 | {2'b0, cp[5:0]});
      end else begin
         put_data(8'hF0 | {5'b0, cp[20:18]});
         put_data(8'h80 | {2'b0, cp[17:12]});
         put_data(8'h80 | {2'b0, cp[11:6]});
         put_data(8'h80 | {2'b0, cp[5:0]});
      end
   endtask

   function automatic int digit_value(input logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
   endfunction

   task automatic body_byte(input logic [7:0] b);
      if (b == jsu_pkg::CharQuote) begin
         put_status(jsu_pkg::StatusClosed);
      end else if (b == jsu_pkg::CharNul) begin
         put_status(jsu_pkg::StatusEnded);
      end else if (b == jsu_pkg::CharBackslash) begin
         parser_mode = jsu_pkg::ModeEsc;
      end else begin
         put_data(b);
         parser_mode = jsu_pkg::ModeStr;
      end
   endtask

   task automatic after_backslash(input logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (b == jsu_pkg::CharNul) begin
         put_status(jsu_pkg::StatusEnded);
      end else if (b == jsu_pkg::CharU) begin
         parser_mode   = jsu_pkg::ModeHex;
         digits_taken  = 3'd0;
         code_gathered = 16'h0;
      end else begin
         case (b)
            jsu_pkg::CharB: c = jsu_pkg::CtlBackspace;
            jsu_pkg::CharF: c = jsu_pkg::CtlFormFeed;
            jsu_pkg::CharN: c = jsu_pkg::CtlLineFeed;
            jsu_pkg::CharR: c = jsu_pkg::CtlReturn;
            jsu_pkg::CharT: c = jsu_pkg::CtlTab;
            default:        c = b;
         endcase
         put_data(c);
         parser_mode = jsu_pkg::ModeStr;
      end
   endtask

   // A high surrogate is held back until we know whether a low one follows.
   task automatic code_complete(input logic [15:0] cp);
      if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
         high_half   = cp;
         parser_mode = jsu_pkg::ModeWaitBs;
      end else begin
         put_utf8({5'b0, cp});
         parser_mode = jsu_pkg::ModeStr;
      end
   endtask

   task automatic decode_raw_byte(input logic [7:0] b);
      int                    first;
      int                    v;
      jsu_pkg::rsp_item_type tail;
      first = decoded_q.size();
      v     = digit_value(b);
      case (parser_mode)
         jsu_pkg::ModeStr: body_byte(b);
         jsu_pkg::ModeEsc: after_backslash(b);
         jsu_pkg::ModeHex: begin
            if (v < 0) begin
               put_data(jsu_pkg::CharQuestion);
               body_byte(b);
            end else begin
               code_gathered = {code_gathered[11:0], v[3:0]};
               digits_taken  = digits_taken + 3'd1;
               if (digits_taken >= 3'd4) code_complete(code_gathered);
            end
         end
         jsu_pkg::ModeWaitBs: begin
            if (b == jsu_pkg::CharBackslash) begin
               parser_mode = jsu_pkg::ModeWaitU;
            end else begin
               put_utf8({5'b0, high_half});
               body_byte(b);
            end
         end
         jsu_pkg::ModeWaitU: begin
            if (b == jsu_pkg::CharU) begin
               parser_mode   = jsu_pkg::ModeLowHex;
               digits_taken  = 3'd0;
               code_gathered = 16'h0;
            end else begin
               put_utf8({5'b0, high_half});
               after_backslash(b);
            end
         end
         jsu_pkg::ModeLowHex: begin
            if (v < 0) begin
               put_utf8({5'b0, high_half});
               put_data(jsu_pkg::CharQuestion);
               body_byte(b);
            end else begin
               code_gathered = {code_gathered[11:0], v[3:0]};
               digits_taken  = digits_taken + 3'd1;
               if (digits_taken >= 3'd4) begin
                  if (code_gathered >= 16'hDC00 && code_gathered <= 16'hDFFF) begin
                     put_utf8(21'h10000 + (21'(high_half - 16'hD800) << 10)
                              + 21'(code_gathered - 16'hDC00));
                     parser_mode = jsu_pkg::ModeStr;
                  end else begin
                     put_utf8({5'b0, high_half});
                     code_complete(code_gathered);
                  end
               end
            end
         end
         default: begin
            if (b == jsu_pkg::CharQuote) parser_mode = jsu_pkg::ModeStr;
            else put_status(jsu_pkg::StatusNoQuote);
         end
      endcase
      if (decoded_q.size() > first) begin
         tail      = decoded_q.pop_back();
         tail.last = 1'b1;
         decoded_q.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      jsu_pkg::rsp_item_type got;
      jsu_pkg::rsp_item_type want;
      if (reset) begin
         parser_mode   = jsu_pkg::ModeIdle;
         digits_taken  = 3'd0;
         code_gathered = 16'h0;
         high_half     = 16'h0;
         decoded_q.delete();
      end else begin
         // Results are offered in the cycle after their request at the earliest, so
         // a result seen at this edge never belongs to a request taken here.
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte   = rsp_tdata;
            got.byte_valid = rsp_tuser[0];
            got.status     = rsp_tuser[2:1];
            got.last       = rsp_tlast;
            if (decoded_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result byte=%h valid=%b status=%0d last=%b",
                           $realtime, got.out_byte, got.byte_valid, got.status, got.last);
               fail_count++;
            end else begin
               want = decoded_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"%0t: mismatch expected byte=%h valid=%b status=%0d last=%b,",
                               " got byte=%h valid=%b status=%0d last=%b"}, $realtime,
                              want.out_byte, want.byte_valid, want.status, want.last,
                              got.out_byte, got.byte_valid, got.status, got.last);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) decode_raw_byte(req_tdata);
      end
      failures    <= fail_count;
      outstanding <= decoded_q.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Feeds raw JSON string bytes into the unescaper, first a directed set of
// escapes, surrogates and broken sequences, then random strings under
// several idle and stall patterns, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module testbench;

   localparam int HoldCycles  = 300;    // long receiver hold-off for back-pressure
   localparam int QuietLimit  = 4000;   // cycles without any transfer before giving up
   localparam int DrainCycles = 20;

   // All inputs of the block start at known values.
   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic [2:0] rsp_tuser;            // [0] byte_valid, [2:1] status
   logic       rsp_tlast;

   int   failures;
   int   outstanding;
   int   quiet_cycles  = 0;
   int   sent_count    = 0;
   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   int   hold_requests = 0;

   json_string_unescape_utf8 DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   utf8_unescape_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // The receiver normally stalls at random. When the stimulus asks for a
   // hold-off, it keeps tready low for a long fixed stretch so that the block
   // backs up and has to stall its request side.
   initial begin
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            rsp_tready <= (int'($urandom_range(99)) >= stall_pct);
         end
      end
   end

   // Watchdog: any transfer on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < QuietLimit);
      $display("RESULT: ERROR");
      $finish;
   end

   // Offers one raw byte, possibly after a random gap, and returns at the edge
   // where the request is accepted.
   task automatic send_byte(input logic [7:0] b);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Hex digits come in both letter cases.
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      if ($urandom_range(1) == 0) return 8'h61 + 8'(v) - 8'd10;
      return 8'h41 + 8'(v) - 8'd10;
   endfunction

   task automatic send_code(input logic [15:0] cp);
      send_byte(jsu_pkg::CharBackslash);
      send_byte(jsu_pkg::CharU);
      for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[i*4 +: 4]));
   endtask

   // A byte that can never be a hex digit; some of them also close, end or
   // escape the string once they are handled again inside it.
   function automatic logic [7:0] bad_digit();
      case ($urandom_range(6))
         0: return "g";
         1: return "x";
         2: return " ";
         3: return jsu_pkg::CharQuote;
         4: return jsu_pkg::CharNul;
         5: return jsu_pkg::CharBackslash;
         default: return 8'($urandom_range(128, 255));
      endcase
   endfunction

   function automatic logic [15:0] random_code();
      case ($urandom_range(3))
         0: return 16'($urandom_range(0, 16'h7F));
         1: return 16'($urandom_range(16'h80, 16'h7FF));
         2: return 16'($urandom_range(16'h800, 16'hFFFF));
         default: return 16'($urandom_range(16'hE000, 16'hFFFF));
      endcase
   endfunction

   task automatic send_simple_escape();
      send_byte(jsu_pkg::CharBackslash);
      case ($urandom_range(10))
         0: send_byte(jsu_pkg::CharB);
         1: send_byte(jsu_pkg::CharF);
         2: send_byte(jsu_pkg::CharN);
         3: send_byte(jsu_pkg::CharR);
         4: send_byte(jsu_pkg::CharT);
         5: send_byte(jsu_pkg::CharQuote);
         6: send_byte(jsu_pkg::CharBackslash);
         7: send_byte("/");
         8: send_byte(jsu_pkg::CharNul);     // ends the buffer right after the backslash
         default: send_byte(8'($urandom_range(1, 255)));
      endcase
   endtask

   // One piece of a string body.
   task automatic send_token();
      int pick;
      int k;
      pick = $urandom_range(99);
      if (pick < 35) begin
         send_byte(8'($urandom_range(1, 255)));
      end else if (pick < 50) begin
         send_simple_escape();
      end else if (pick < 65) begin
         send_code(random_code());
      end else if (pick < 78) begin
         // Surrogate pair joined into one four-byte sequence.
         send_code(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
         send_code(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
      end else if (pick < 90) begin
         // High surrogate whose partner never arrives in valid form.
         send_code(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
         case ($urandom_range(4))
            0: send_byte(8'($urandom_range(1, 255)));
            1: send_simple_escape();
            2: send_code(16'($urandom_range(0, 16'hDBFF)));
            3: send_code(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
            default: begin
               send_byte(jsu_pkg::CharBackslash);
               send_byte(jsu_pkg::CharU);
               k = $urandom_range(3);
               repeat (k) send_byte(hex_char(4'($urandom_range(15))));
               send_byte(bad_digit());
            end
         endcase
      end else begin
         // Broken unicode escape: up to three good digits, then a bad one.
         send_byte(jsu_pkg::CharBackslash);
         send_byte(jsu_pkg::CharU);
         k = $urandom_range(3);
         repeat (k) send_byte(hex_char(4'($urandom_range(15))));
         send_byte(bad_digit());
      end
   endtask

   // A full string literal with random content; most are closed properly,
   // some end the buffer and a few are left open for the next quote to close.
   task automatic send_string();
      int pick;
      send_byte(jsu_pkg::CharQuote);
      repeat ($urandom_range(1, 8)) send_token();
      pick = $urandom_range(99);
      if (pick < 85) send_byte(jsu_pkg::CharQuote);
      else if (pick < 95) send_byte(jsu_pkg::CharNul);
   endtask

   initial begin
      int base;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, no idling on either side.
      // Bytes seen while idle that are not quotes, the zero byte among them.
      send_byte(jsu_pkg::CharNul);
      send_byte(8'hFF);
      // Plain bytes at both ends of the range, then every named escape, an
      // unknown one, and the escaped quote, slash and backslash.
      send_text("\"A");
      send_byte(8'hFF);
      send_byte(8'h01);
      send_text("\\b\\f\\n\\r\\t\\q\\/\\\"\\\\");
      // Code point zero, two and three byte forms, a joined surrogate pair.
      send_text("\\u0000\\u00e9\\u07FF\\uFFFF\\uD83D\\uDE00\"");
      // Largest pair, then a bad digit that is handled again as a plain byte.
      send_text("\"\\uDBFF\\uDFFFx\\u12G\"");
      // Lone high surrogates followed by a plain byte, another escape, a bad
      // digit in the low half, a non-low code point, and a second high one.
      // The final bad digit is a quote, so it closes the string after '?'.
      send_text("\"\\uD800x\\uD801\\n\\uD802\\u12Z\\uDBFF\\u0041\\uD803\\uD804\\uDC00\\u1\"");
      // Buffer ending inside a string, after a backslash, inside hex digits,
      // and while a high surrogate waits.
      send_text("\"abc");
      send_byte(jsu_pkg::CharNul);
      send_text("\"\\");
      send_byte(jsu_pkg::CharNul);
      send_text("\"\\u12");
      send_byte(jsu_pkg::CharNul);
      send_text("\"\\uD800\\");
      send_byte(jsu_pkg::CharNul);
      send_text("\"\\uD800");
      send_byte(jsu_pkg::CharNul);

      // Back-pressure: the receiver holds off while strings keep coming.
      hold_requests++;
      repeat (2) send_string();

      // Random part in four idling phases.
      base = sent_count;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 59; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 59; end
            default: begin send_idle_pct = 31; stall_pct <= 31; end
         endcase
         while (sent_count - base < 28 * (phase + 1)) begin
            if ($urandom_range(99) < 85) send_string();
            else repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
         end
      end
      req_tvalid <= 1'b0;

      // Drain: wait for every predicted result, then a little longer so that
      // any stray result still shows up.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (failures == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_decode.sv
hdl/jsu_rsp_queue.sv
hdl/json_string_unescape_utf8.sv
hdl/jsu_checker.sv
bench/utf8_unescape_checker.sv
bench/testbench.sv
